// File: rtl/core/dcos_pkg.sv
package dcos_pkg;

  localparam int COLUMN_BITS_DEFAULT = 10;
  localparam int COORD_BITS_DEFAULT  = 14;

  localparam int FRAC_BITS   = 14;
  localparam int TILT_BITS   = 16;
  localparam int OFFSET_BITS = 13;
  localparam int BAND_BITS   = 13;
  localparam int GAP_BITS    = 10;

  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 16;

  localparam int QUEUE_DEPTH = 4;

  localparam logic [CFG_INDEX_BITS-1:0] REG_TILT_SINE        = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_TILT_COSINE      = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_DEPTH_OFFSET     = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_DEPTH_BAND_LOW   = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_DEPTH_BAND_HIGH  = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_HEIGHT_BAND_LOW  = 3'd5;
  localparam logic [CFG_INDEX_BITS-1:0] REG_HEIGHT_BAND_HIGH = 3'd6;
  localparam logic [CFG_INDEX_BITS-1:0] REG_GAP_LIMIT        = 3'd7;

  localparam logic signed [TILT_BITS-1:0]   TILT_SINE_RESET        = 16'sd6533;
  localparam logic signed [TILT_BITS-1:0]   TILT_COSINE_RESET      = 16'sd15025;
  localparam logic signed [OFFSET_BITS-1:0] DEPTH_OFFSET_RESET     = -13'sd560;
  localparam logic [BAND_BITS-1:0]          DEPTH_BAND_LOW_RESET   = 13'd800;
  localparam logic [BAND_BITS-1:0]          DEPTH_BAND_HIGH_RESET  = 13'd2500;
  localparam logic signed [BAND_BITS-1:0]   HEIGHT_BAND_LOW_RESET  = 13'sd198;
  localparam logic signed [BAND_BITS-1:0]   HEIGHT_BAND_HIGH_RESET = 13'sd264;
  localparam logic [GAP_BITS-1:0]           GAP_LIMIT_RESET        = 10'd10;

  typedef struct packed {
    logic signed [TILT_BITS-1:0]   tilt_sine;
    logic signed [TILT_BITS-1:0]   tilt_cosine;
    logic signed [OFFSET_BITS-1:0] depth_offset;
    logic [BAND_BITS-1:0]          depth_band_low;
    logic [BAND_BITS-1:0]          depth_band_high;
    logic signed [BAND_BITS-1:0]   height_band_low;
    logic signed [BAND_BITS-1:0]   height_band_high;
    logic [GAP_BITS-1:0]           gap_limit;
  } cfg_t;

endpackage

// File: rtl/core/dcos_front.sv
module dcos_front #(
  parameter int COLUMN_BITS = 10,
  parameter int COORD_BITS  = 14
) (
  input  logic                          clk,
  input  logic                          rst,
  input  dcos_pkg::cfg_t                cfg,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [COLUMN_BITS-1:0]        in_column,
  input  logic signed [COORD_BITS-1:0]  in_lateral,
  input  logic signed [COORD_BITS-1:0]  in_height,
  input  logic signed [COORD_BITS-1:0]  in_depth,
  input  logic                          in_column_end,
  input  logic                          in_frame_end,
  output logic                          ev_push,
  output logic [COLUMN_BITS+1:0]        ev_data,
  input  logic                          q_full
);
  import dcos_pkg::*;

  localparam int PW = TILT_BITS + COORD_BITS;
  localparam int ZW = COORD_BITS + 4;

  logic                         s1_valid;
  logic signed [PW-1:0]         s1_prod_s;
  logic signed [PW-1:0]         s1_prod_c;
  logic signed [COORD_BITS-1:0] s1_height;
  logic [COLUMN_BITS-1:0]       s1_column;
  logic                         s1_column_end;
  logic                         s1_frame_end;
  logic                         column_hit;

  logic                  accept;
  logic                  s1_drain;
  logic                  closes;
  logic [PW:0]           prod_sum;
  logic signed [ZW-1:0]  zc;
  logic signed [ZW-1:0]  depth_lo;
  logic signed [ZW-1:0]  depth_hi;
  logic signed [ZW-1:0]  height_ext;
  logic signed [ZW-1:0]  height_lo;
  logic signed [ZW-1:0]  height_hi;
  logic                  in_band;
  logic                  height_ok;
  logic                  hit_now;

  assign s1_drain = s1_valid && !q_full;
  assign in_ready = !s1_valid || !q_full;
  assign accept   = in_valid && in_ready;
  assign closes   = s1_column_end || s1_frame_end;

  assign prod_sum = {s1_prod_s[PW-1], s1_prod_s} + {s1_prod_c[PW-1], s1_prod_c};
  assign zc = {prod_sum[PW], prod_sum[PW:FRAC_BITS]}
            + {{(ZW-OFFSET_BITS){cfg.depth_offset[OFFSET_BITS-1]}}, cfg.depth_offset};
  assign depth_lo   = {{(ZW-BAND_BITS){1'b0}}, cfg.depth_band_low};
  assign depth_hi   = {{(ZW-BAND_BITS){1'b0}}, cfg.depth_band_high};
  assign height_ext = {{(ZW-COORD_BITS){s1_height[COORD_BITS-1]}}, s1_height};
  assign height_lo  = {{(ZW-BAND_BITS){cfg.height_band_low[BAND_BITS-1]}},
                       cfg.height_band_low};
  assign height_hi  = {{(ZW-BAND_BITS){cfg.height_band_high[BAND_BITS-1]}},
                       cfg.height_band_high};

  assign in_band   = (zc > depth_lo) && (zc < depth_hi);
  assign height_ok = (height_ext >= height_lo) && (height_ext <= height_hi);
  assign hit_now   = in_band ? height_ok : column_hit;

  assign ev_push = s1_drain && closes;
  assign ev_data = {s1_frame_end, hit_now, s1_column};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      column_hit <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_drain) begin
        s1_valid <= 1'b0;
      end
      if (s1_drain) begin
        column_hit <= closes ? 1'b0 : hit_now;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_prod_s     <= cfg.tilt_sine * in_lateral;
      s1_prod_c     <= cfg.tilt_cosine * in_depth;
      s1_height     <= in_height;
      s1_column     <= in_column;
      s1_column_end <= in_column_end;
      s1_frame_end  <= in_frame_end;
    end
  end

endmodule

// File: rtl/core/dcos_queue.sv
module dcos_queue #(
  parameter int W = 12
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] pop_data,
  output logic         empty
);
  import dcos_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [W-1:0]     mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = count == CNT_W'(QUEUE_DEPTH);
  assign empty    = count == '0;
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

// File: rtl/core/dcos_back.sv
module dcos_back #(
  parameter int COLUMN_BITS = 10
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [dcos_pkg::GAP_BITS-1:0] gap_limit,
  input  logic                        ev_valid,
  input  logic [COLUMN_BITS+1:0]      ev_data,
  output logic                        ev_pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [2*COLUMN_BITS+1:0]    out_data,
  output logic                        busy
);
  import dcos_pkg::*;

  localparam int SW    = 2 * COLUMN_BITS;
  localparam int CW    = COLUMN_BITS + 1;
  localparam int GW    = ((COLUMN_BITS > GAP_BITS) ? COLUMN_BITS : GAP_BITS) + 2;
  localparam int CNT_W = $clog2(SW);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_DIV_A = 3'b010,
    ST_DIV_B = 3'b100
  } back_state_t;

  back_state_t            state;
  logic [SW-1:0]          run_sum;
  logic [CW-1:0]          run_count;
  logic [COLUMN_BITS-1:0] run_last;
  logic [SW-1:0]          group_sum;
  logic [CW-1:0]          group_count;
  logic [COLUMN_BITS-1:0] held_first;
  logic [COLUMN_BITS-1:0] held_second;
  logic [CW-1:0]          div_rem;
  logic [SW-1:0]          div_quo;
  logic [CW-1:0]          div_den;
  logic [CNT_W-1:0]       div_cnt;
  logic [SW-1:0]          b_num;
  logic [CW-1:0]          b_den;
  logic                   b_pending;

  logic [COLUMN_BITS-1:0] ev_col;
  logic                   ev_hit;
  logic                   ev_frame_end;
  logic signed [GW-1:0]   gap;
  logic signed [GW-1:0]   gap_max;
  logic                   split;
  logic [SW-1:0]          rs0;
  logic [CW-1:0]          rc0;
  logic [SW:0]            add_sum;
  logic                   can_add;
  logic [SW-1:0]          n_run_sum;
  logic [CW-1:0]          n_run_count;
  logic [COLUMN_BITS-1:0] n_run_last;
  logic [SW-1:0]          n_group_sum;
  logic [CW-1:0]          n_group_count;
  logic                   group_found;
  logic                   run_found;
  logic [SW-1:0]          a_num;
  logic [CW-1:0]          a_den;
  logic [CW:0]            rem_shift;
  logic [CW:0]            rem_trial;
  logic [CW-1:0]          rem_next;
  logic [SW-1:0]          quo_next;
  logic                   div_last;

  assign ev_col       = ev_data[COLUMN_BITS-1:0];
  assign ev_hit       = ev_data[COLUMN_BITS];
  assign ev_frame_end = ev_data[COLUMN_BITS+1];

  assign busy   = state != ST_IDLE;
  assign ev_pop = ev_valid && (state == ST_IDLE) && (!ev_frame_end || !out_valid);

  assign gap     = GW'(ev_col) - GW'(run_last);
  assign gap_max = {{(GW-GAP_BITS){1'b0}}, gap_limit};
  assign split   = ev_hit && (run_count != '0) && (gap > gap_max);
  assign rs0     = split ? '0 : run_sum;
  assign rc0     = split ? '0 : run_count;
  assign add_sum = {1'b0, rs0} + (SW+1)'(ev_col);
  assign can_add = !add_sum[SW] && (rc0 != '1);

  assign n_run_sum     = (ev_hit && can_add) ? add_sum[SW-1:0] : rs0;
  assign n_run_count   = (ev_hit && can_add) ? rc0 + 1'b1 : rc0;
  assign n_run_last    = ev_hit ? ev_col : run_last;
  assign n_group_sum   = split ? run_sum : group_sum;
  assign n_group_count = split ? run_count : group_count;

  assign group_found = n_group_count != '0;
  assign run_found   = n_run_count != '0;
  assign a_num       = group_found ? n_group_sum : n_run_sum;
  assign a_den       = group_found ? n_group_count : n_run_count;

  assign rem_shift = {div_rem, div_quo[SW-1]};
  assign rem_trial = rem_shift - {1'b0, div_den};
  assign rem_next  = rem_trial[CW] ? rem_shift[CW-1:0] : rem_trial[CW-1:0];
  assign quo_next  = {div_quo[SW-2:0], !rem_trial[CW]};
  assign div_last  = div_cnt == CNT_W'(SW - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      run_sum     <= '0;
      run_count   <= '0;
      run_last    <= '0;
      group_sum   <= '0;
      group_count <= '0;
      held_first  <= '0;
      held_second <= '0;
      out_valid   <= 1'b0;
      b_pending   <= 1'b0;
      div_cnt     <= '0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (ev_pop) begin
            if (ev_frame_end) begin
              run_sum     <= '0;
              run_count   <= '0;
              run_last    <= '0;
              group_sum   <= '0;
              group_count <= '0;
              b_pending   <= group_found && run_found;
              b_num       <= n_run_sum;
              b_den       <= n_run_count;
              if (group_found || run_found) begin
                div_rem <= '0;
                div_quo <= a_num;
                div_den <= a_den;
                div_cnt <= '0;
                state   <= ST_DIV_A;
              end else begin
                out_valid <= 1'b1;
                out_data  <= {held_second, 1'b0, held_first, 1'b0};
              end
            end else begin
              run_sum     <= n_run_sum;
              run_count   <= n_run_count;
              run_last    <= n_run_last;
              group_sum   <= n_group_sum;
              group_count <= n_group_count;
            end
          end
        end
        ST_DIV_A, ST_DIV_B: begin
          div_rem <= rem_next;
          div_quo <= quo_next;
          div_cnt <= div_cnt + 1'b1;
          if (div_last) begin
            if (state == ST_DIV_A) begin
              held_first <= quo_next[COLUMN_BITS-1:0];
              if (b_pending) begin
                div_rem <= '0;
                div_quo <= b_num;
                div_den <= b_den;
                div_cnt <= '0;
                state   <= ST_DIV_B;
              end else begin
                out_valid <= 1'b1;
                out_data  <= {held_second, 1'b0, quo_next[COLUMN_BITS-1:0], 1'b1};
                state     <= ST_IDLE;
              end
            end else begin
              held_second <= quo_next[COLUMN_BITS-1:0];
              out_valid   <= 1'b1;
              out_data    <= {quo_next[COLUMN_BITS-1:0], 1'b1, held_first, 1'b1};
              state       <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// File: rtl/core/depth_column_obstacle_segmenter.sv
// Channel | Direction | Handshake           | Payload
// s       | in        | s_tvalid / s_tready | s_tdata points, s_tuser column end, s_tlast frame end
// m       | out       | m_tvalid / m_tready | m_tdata frame result
// cfg     | in        | cfg_valid/cfg_ready | cfg_index register, cfg_data value
//
// A point is taken every cycle while the queue is not full; each one is registered in the front stage.
// Column closes enter a four-entry queue that the back end drains one per cycle while it is idle.
// A frame end divides each group found in the shared divider, which keeps the back end busy.
// Input stalls only when the queue is full; a waiting result holds frame ends in the queue, so it can stall points.
// Reset is synchronous; it clears all run state and loads the register defaults.
module depth_column_obstacle_segmenter
  import dcos_pkg::*;
#(
  parameter int COLUMN_BITS = dcos_pkg::COLUMN_BITS_DEFAULT,
  parameter int COORD_BITS  = dcos_pkg::COORD_BITS_DEFAULT,
  localparam int IN_W   = COLUMN_BITS + 3 * COORD_BITS,
  localparam int IN_TW  = ((IN_W + 7) / 8) * 8,
  localparam int OUT_W  = 2 * COLUMN_BITS + 2,
  localparam int OUT_TW = ((OUT_W + 7) / 8) * 8
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  // column_index, point_lateral, point_height, point_depth
  input  logic [IN_TW-1:0]                      s_tdata,
  // column_end
  input  logic                                  s_tuser,
  input  logic                                  s_tlast,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  // first_valid, first_column, second_valid, second_column
  output logic [OUT_TW-1:0]                     m_tdata,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [dcos_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [dcos_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

  localparam int EV_W = COLUMN_BITS + 2;

  cfg_t              cfg_regs;
  logic              q_push;
  logic [EV_W-1:0]   q_push_data;
  logic              q_full;
  logic              q_pop;
  logic [EV_W-1:0]   q_pop_data;
  logic              q_empty;
  logic              back_busy;
  logic [OUT_W-1:0]  out_data;

  assign cfg_ready = 1'b1;
  assign m_tdata   = {{(OUT_TW-OUT_W){1'b0}}, out_data};

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.tilt_sine        <= TILT_SINE_RESET;
      cfg_regs.tilt_cosine      <= TILT_COSINE_RESET;
      cfg_regs.depth_offset     <= DEPTH_OFFSET_RESET;
      cfg_regs.depth_band_low   <= DEPTH_BAND_LOW_RESET;
      cfg_regs.depth_band_high  <= DEPTH_BAND_HIGH_RESET;
      cfg_regs.height_band_low  <= HEIGHT_BAND_LOW_RESET;
      cfg_regs.height_band_high <= HEIGHT_BAND_HIGH_RESET;
      cfg_regs.gap_limit        <= GAP_LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_TILT_SINE:        cfg_regs.tilt_sine        <= cfg_data[TILT_BITS-1:0];
        REG_TILT_COSINE:      cfg_regs.tilt_cosine      <= cfg_data[TILT_BITS-1:0];
        REG_DEPTH_OFFSET:     cfg_regs.depth_offset     <= cfg_data[OFFSET_BITS-1:0];
        REG_DEPTH_BAND_LOW:   cfg_regs.depth_band_low   <= cfg_data[BAND_BITS-1:0];
        REG_DEPTH_BAND_HIGH:  cfg_regs.depth_band_high  <= cfg_data[BAND_BITS-1:0];
        REG_HEIGHT_BAND_LOW:  cfg_regs.height_band_low  <= cfg_data[BAND_BITS-1:0];
        REG_HEIGHT_BAND_HIGH: cfg_regs.height_band_high <= cfg_data[BAND_BITS-1:0];
        REG_GAP_LIMIT:        cfg_regs.gap_limit        <= cfg_data[GAP_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  dcos_front #(
    .COLUMN_BITS(COLUMN_BITS),
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg_regs),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .in_column    (s_tdata[COLUMN_BITS-1:0]),
    .in_lateral   (s_tdata[COLUMN_BITS+COORD_BITS-1:COLUMN_BITS]),
    .in_height    (s_tdata[COLUMN_BITS+2*COORD_BITS-1:COLUMN_BITS+COORD_BITS]),
    .in_depth     (s_tdata[COLUMN_BITS+3*COORD_BITS-1:COLUMN_BITS+2*COORD_BITS]),
    .in_column_end(s_tuser),
    .in_frame_end (s_tlast),
    .ev_push      (q_push),
    .ev_data      (q_push_data),
    .q_full       (q_full)
  );

  dcos_queue #(
    .W(EV_W)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_data(q_push_data),
    .full     (q_full),
    .pop      (q_pop),
    .pop_data (q_pop_data),
    .empty    (q_empty)
  );

  dcos_back #(
    .COLUMN_BITS(COLUMN_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .gap_limit(cfg_regs.gap_limit),
    .ev_valid (!q_empty),
    .ev_data  (q_pop_data),
    .ev_pop   (q_pop),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .out_data (out_data),
    .busy     (back_busy)
  );

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("column event pushed into a full queue");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("column event popped from an empty queue");

  a_no_result_while_dividing: assert property (@(posedge clk) disable iff (rst)
    back_busy |-> !m_tvalid)
    else $error("frame result pending while the divider is running");

endmodule

// File: tb/tb.sv
module tb;
  import dcos_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int COLUMN_BITS = COLUMN_BITS_DEFAULT;
  localparam int COORD_BITS = COORD_BITS_DEFAULT;
  localparam int IN_W = COLUMN_BITS + 3 * COORD_BITS;
  localparam int IN_TW = ((IN_W + 7) / 8) * 8;
  localparam int OUT_W = 2 * COLUMN_BITS + 2;
  localparam int OUT_TW = ((OUT_W + 7) / 8) * 8;
  localparam int SUM_LIMIT = (1 << (2 * COLUMN_BITS)) - 1;
  localparam int COUNT_LIMIT = (1 << (COLUMN_BITS + 1)) - 1;
  localparam int COLUMN_MAX = (1 << COLUMN_BITS) - 1;
  localparam int DRAIN_CYCLES = 100;
  localparam int HOLD_AT = 8;
  localparam int HOLD_CYCLES = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int NUM_PHASES = 8;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] depth;
    logic signed [COORD_BITS-1:0] height;
    logic signed [COORD_BITS-1:0] lateral;
    logic [COLUMN_BITS-1:0] column;
  } point_t;

  typedef struct packed {
    logic [COLUMN_BITS-1:0] second_column;
    logic second_valid;
    logic [COLUMN_BITS-1:0] first_column;
    logic first_valid;
  } frame_result_t;

  typedef enum {POINT_HIT, POINT_MISS, POINT_OUTSIDE} point_kind_e;

  typedef struct {
    int col;
    int lat;
    int hgt;
    int dep;
    bit cend;
    bit fend;
    bit typed;
    frame_result_t want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_TW-1:0] s_tdata = '0;
  logic s_tuser = 1'b0;
  logic s_tlast = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_TW-1:0] m_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  depth_column_obstacle_segmenter dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .s_tlast(s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  cfg_t shadow_cfg;
  bit col_obstacle;
  bit [2*COLUMN_BITS-1:0] run_col_sum;
  bit [COLUMN_BITS:0] run_col_count;
  bit [COLUMN_BITS-1:0] run_prev_col;
  bit [2*COLUMN_BITS-1:0] grp1_col_sum;
  bit [COLUMN_BITS:0] grp1_col_count;
  bit [COLUMN_BITS-1:0] last_first;
  bit [COLUMN_BITS-1:0] last_second;

  frame_result_t pending_results[$];
  int error_count = 0;
  int items_sent = 0;
  int idle_cycles = 0;
  bit sender_burst = 1'b0;

  dir_row_t dir_rows [13] = '{
    '{0, 0, 0, 0, 1'b0, 1'b1, 1'b1, '0},
    '{0, -8192, -8192, -8192, 1'b1, 1'b0, 1'b0, '0},
    '{1023, 8191, 8191, 8191, 1'b1, 1'b0, 1'b0, '0},
    '{5, 0, 200, 2000, 1'b1, 1'b0, 1'b0, '0},
    '{6, 0, 200, 2000, 1'b0, 1'b0, 1'b0, '0},
    '{6, 0, 8191, 2000, 1'b1, 1'b0, 1'b0, '0},
    '{7, 0, 200, 2000, 1'b0, 1'b0, 1'b0, '0},
    '{7, 0, 8191, 0, 1'b1, 1'b0, 1'b0, '0},
    '{30, 0, 264, 2000, 1'b1, 1'b0, 1'b0, '0},
    '{25, 0, 198, 2000, 1'b1, 1'b0, 1'b0, '0},
    '{40, 0, 200, 2000, 1'b0, 1'b1, 1'b0, '0},
    '{1023, 0, 200, 2000, 1'b1, 1'b1, 1'b1,
      '{first_valid: 1'b1, first_column: 10'd1023, second_valid: 1'b0, second_column: 10'd40}},
    '{0, 0, 0, 0, 1'b0, 1'b1, 1'b1,
      '{first_valid: 1'b0, first_column: 10'd1023, second_valid: 1'b0, second_column: 10'd40}}
  };

  function automatic longint corrected_depth(point_t p);
    longint prod;
    prod = longint'(shadow_cfg.tilt_sine) * longint'(p.lateral)
         + longint'(shadow_cfg.tilt_cosine) * longint'(p.depth);
    return (prod >>> FRAC_BITS) + longint'(shadow_cfg.depth_offset);
  endfunction

  function automatic bit depth_in_band(point_t p);
    longint zc;
    zc = corrected_depth(p);
    return zc > longint'(shadow_cfg.depth_band_low) && zc < longint'(shadow_cfg.depth_band_high);
  endfunction

  function automatic bit height_in_band(point_t p);
    return int'(p.height) >= int'(shadow_cfg.height_band_low)
        && int'(p.height) <= int'(shadow_cfg.height_band_high);
  endfunction

  function automatic void reset_segmenter();
    shadow_cfg.tilt_sine = TILT_SINE_RESET;
    shadow_cfg.tilt_cosine = TILT_COSINE_RESET;
    shadow_cfg.depth_offset = DEPTH_OFFSET_RESET;
    shadow_cfg.depth_band_low = DEPTH_BAND_LOW_RESET;
    shadow_cfg.depth_band_high = DEPTH_BAND_HIGH_RESET;
    shadow_cfg.height_band_low = HEIGHT_BAND_LOW_RESET;
    shadow_cfg.height_band_high = HEIGHT_BAND_HIGH_RESET;
    shadow_cfg.gap_limit = GAP_LIMIT_RESET;
    col_obstacle = 1'b0;
    run_col_sum = '0;
    run_col_count = '0;
    run_prev_col = '0;
    grp1_col_sum = '0;
    grp1_col_count = '0;
    last_first = '0;
    last_second = '0;
  endfunction

  function automatic void store_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
    case (idx)
      REG_TILT_SINE: shadow_cfg.tilt_sine = data;
      REG_TILT_COSINE: shadow_cfg.tilt_cosine = data;
      REG_DEPTH_OFFSET: shadow_cfg.depth_offset = data[OFFSET_BITS-1:0];
      REG_DEPTH_BAND_LOW: shadow_cfg.depth_band_low = data[BAND_BITS-1:0];
      REG_DEPTH_BAND_HIGH: shadow_cfg.depth_band_high = data[BAND_BITS-1:0];
      REG_HEIGHT_BAND_LOW: shadow_cfg.height_band_low = data[BAND_BITS-1:0];
      REG_HEIGHT_BAND_HIGH: shadow_cfg.height_band_high = data[BAND_BITS-1:0];
      REG_GAP_LIMIT: shadow_cfg.gap_limit = data[GAP_BITS-1:0];
      default: ;
    endcase
  endfunction

  // A column closes on its column-end point or on the frame end; the frame end also reports up to two groups.
  function automatic bit segment_point(point_t p, bit cend, bit fend, output frame_result_t res);
    int gap;
    res = '0;
    if (depth_in_band(p)) begin
      col_obstacle = height_in_band(p);
    end
    if (cend || fend) begin
      if (col_obstacle) begin
        gap = int'(p.column) - int'(run_prev_col);
        if (run_col_count != 0 && gap > int'(shadow_cfg.gap_limit)) begin
          grp1_col_sum = run_col_sum;
          grp1_col_count = run_col_count;
          run_col_sum = '0;
          run_col_count = '0;
        end
        if (int'(run_col_count) < COUNT_LIMIT && int'(run_col_sum) + int'(p.column) <= SUM_LIMIT) begin
          run_col_sum = run_col_sum + p.column;
          run_col_count = run_col_count + 1'b1;
        end
        run_prev_col = p.column;
      end
      col_obstacle = 1'b0;
    end
    if (!fend) begin
      return 1'b0;
    end
    if (grp1_col_count != 0 && run_col_count != 0) begin
      last_first = COLUMN_BITS'(grp1_col_sum / grp1_col_count);
      last_second = COLUMN_BITS'(run_col_sum / run_col_count);
      res.first_valid = 1'b1;
      res.second_valid = 1'b1;
    end else if (run_col_count != 0) begin
      last_first = COLUMN_BITS'(run_col_sum / run_col_count);
      res.first_valid = 1'b1;
    end else if (grp1_col_count != 0) begin
      last_first = COLUMN_BITS'(grp1_col_sum / grp1_col_count);
      res.first_valid = 1'b1;
    end
    res.first_column = last_first;
    res.second_column = last_second;
    run_col_sum = '0;
    run_col_count = '0;
    run_prev_col = '0;
    grp1_col_sum = '0;
    grp1_col_count = '0;
    col_obstacle = 1'b0;
    return 1'b1;
  endfunction

  function automatic point_t make_point(int col, point_kind_e kind);
    point_t p;
    int lo;
    int hi;
    int base;
    bit identity;
    lo = int'(shadow_cfg.height_band_low);
    hi = int'(shadow_cfg.height_band_high);
    identity = shadow_cfg.tilt_sine == 0 && shadow_cfg.tilt_cosine == 16384;
    p.column = col;
    for (int tries = 0; tries < 64; tries++) begin
      p.lateral = $urandom;
      p.depth = $urandom;
      if (identity && $urandom_range(0, 3) == 0) begin
        base = $urandom_range(0, 1) ? int'(shadow_cfg.depth_band_low) : int'(shadow_cfg.depth_band_high);
        p.depth = base - int'(shadow_cfg.depth_offset) + int'($urandom_range(0, 2)) - 1;
      end
      if (depth_in_band(p) == (kind != POINT_OUTSIDE)) begin
        break;
      end
    end
    p.height = $urandom;
    if (kind == POINT_MISS) begin
      if (lo <= hi && $urandom_range(0, 3) == 0) begin
        p.height = $urandom_range(0, 1) ? lo - 1 : hi + 1;
      end else begin
        for (int tries = 0; tries < 16 && height_in_band(p); tries++) begin
          p.height = $urandom;
        end
      end
    end else if (lo <= hi && (kind == POINT_HIT || $urandom_range(0, 1) == 0)) begin
      if ($urandom_range(0, 3) == 0) begin
        p.height = $urandom_range(0, 1) ? lo : hi;
      end else begin
        p.height = lo + int'($urandom_range(0, hi - lo));
      end
    end
    return p;
  endfunction

  function automatic cfg_t phase_setting(int ph);
    cfg_t c;
    int lo;
    c.tilt_sine = TILT_SINE_RESET;
    c.tilt_cosine = TILT_COSINE_RESET;
    c.depth_offset = DEPTH_OFFSET_RESET;
    c.depth_band_low = DEPTH_BAND_LOW_RESET;
    c.depth_band_high = DEPTH_BAND_HIGH_RESET;
    c.height_band_low = HEIGHT_BAND_LOW_RESET;
    c.height_band_high = HEIGHT_BAND_HIGH_RESET;
    c.gap_limit = GAP_LIMIT_RESET;
    case (ph)
      1: begin
        c.tilt_sine = 0;
        c.tilt_cosine = 16384;
        c.depth_offset = 0;
        c.depth_band_low = 1000;
        c.depth_band_high = 3000;
        c.height_band_low = -100;
        c.height_band_high = 300;
        c.gap_limit = 0;
      end
      2: begin
        c.tilt_sine = -16384;
        c.tilt_cosine = -16384;
        c.depth_offset = 4095;
        c.depth_band_low = 0;
        c.depth_band_high = 8191;
        c.height_band_low = -4096;
        c.height_band_high = 4095;
        c.gap_limit = 1023;
      end
      3: begin
        c.tilt_sine = 16384;
        c.tilt_cosine = 16384;
        c.depth_offset = -4096;
        c.depth_band_low = 100;
        c.depth_band_high = 6000;
        c.height_band_low = 0;
        c.height_band_high = 50;
        c.gap_limit = 0;
      end
      4, 5: begin
        c.tilt_sine = int'($urandom_range(0, 32768)) - 16384;
        c.tilt_cosine = int'($urandom_range(0, 32768)) - 16384;
        c.depth_offset = int'($urandom_range(0, 8191)) - 4096;
        lo = $urandom_range(0, 4000);
        c.depth_band_low = lo;
        c.depth_band_high = $urandom_range(lo, 8191);
        lo = int'($urandom_range(0, 6096)) - 4096;
        c.height_band_low = lo;
        c.height_band_high = lo + int'($urandom_range(0, 4095 - lo));
        c.gap_limit = $urandom_range(0, 3) == 0 ? $urandom_range(0, 1023) : $urandom_range(0, 40);
      end
      6: begin
        c.tilt_sine = 0;
        c.tilt_cosine = 0;
        c.depth_offset = -1;
        c.depth_band_low = 8191;
        c.depth_band_high = 0;
        c.height_band_low = 4095;
        c.height_band_high = -4096;
        c.gap_limit = 1023;
      end
      default: ;
    endcase
    return c;
  endfunction

  function automatic int phase_items(int ph);
    case (ph)
      0: return 400;
      6: return 60;
      7: return 150;
      default: return 230;
    endcase
  endfunction

  task automatic send_point(point_t p, bit cend, bit fend, bit typed = 1'b0, frame_result_t want = '0);
    int gap;
    frame_result_t res;
    gap = sender_burst ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= IN_TW'(p);
    s_tuser <= cend;
    s_tlast <= fend;
    do @(posedge clk); while (!s_tready);
    if (segment_point(p, cend, fend, res)) begin
      pending_results.push_back(typed ? want : res);
    end
    items_sent++;
    if ($urandom_range(0, 31) == 0) begin
      sender_burst = !sender_burst;
    end
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] value, int width);
    logic [CFG_DATA_BITS-1:0] data;
    data = value;
    if (width < CFG_DATA_BITS) begin
      data = (value & ((16'd1 << width) - 16'd1)) | (CFG_DATA_BITS'($urandom) << width);
    end
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    store_reg(idx, data);
  endtask

  task automatic apply_config(cfg_t c);
    write_reg(REG_TILT_SINE, c.tilt_sine, TILT_BITS);
    write_reg(REG_TILT_COSINE, c.tilt_cosine, TILT_BITS);
    write_reg(REG_DEPTH_OFFSET, c.depth_offset, OFFSET_BITS);
    write_reg(REG_DEPTH_BAND_LOW, c.depth_band_low, BAND_BITS);
    write_reg(REG_DEPTH_BAND_HIGH, c.depth_band_high, BAND_BITS);
    write_reg(REG_HEIGHT_BAND_LOW, c.height_band_low, BAND_BITS);
    write_reg(REG_HEIGHT_BAND_HIGH, c.height_band_high, BAND_BITS);
    write_reg(REG_GAP_LIMIT, c.gap_limit, GAP_BITS);
    cfg_valid <= 1'b0;
  endtask

  // Every column repeats one index, so the run never splits and its sum or count saturates.
  task automatic saturating_run(int col, int n);
    for (int i = 0; i < n; i++) begin
      send_point(make_point(col, POINT_HIT), 1'b1, i == n - 1);
    end
  endtask

  task automatic random_frame();
    int ncols;
    int npts;
    int col;
    int r;
    bit cend;
    bit fend;
    point_t p;
    point_kind_e kind;
    if ($urandom_range(0, 9) == 0) begin
      npts = $urandom_range(1, 10);
      for (int i = 0; i < npts; i++) begin
        p.column = $urandom;
        p.lateral = $urandom;
        p.height = $urandom;
        p.depth = $urandom;
        fend = i == npts - 1 || $urandom_range(0, 7) == 0;
        send_point(p, $urandom_range(0, 1), fend);
      end
      return;
    end
    ncols = $urandom_range(1, 10);
    col = $urandom_range(0, 900);
    for (int c = 0; c < ncols; c++) begin
      if (c > 0) begin
        r = $urandom_range(0, 15);
        if (r == 0) begin
          col = col - int'($urandom_range(0, 5));
        end else if (r <= 2) begin
          col = col + int'(shadow_cfg.gap_limit) + int'($urandom_range(1, 20));
        end else begin
          col = col + int'($urandom_range(1, 3));
        end
        col = col < 0 ? 0 : (col > COLUMN_MAX ? COLUMN_MAX : col);
      end
      npts = $urandom_range(1, 4);
      for (int k = 0; k < npts; k++) begin
        r = $urandom_range(0, 9);
        kind = r < 5 ? POINT_HIT : (r < 7 ? POINT_MISS : POINT_OUTSIDE);
        cend = k == npts - 1;
        fend = cend && c == ncols - 1;
        if (fend && $urandom_range(0, 4) == 0) begin
          cend = 1'b0;
        end
        send_point(make_point(col, kind), cend, fend);
      end
    end
  endtask

  task automatic check_result(frame_result_t got);
    frame_result_t want;
    if (pending_results.size() == 0) begin
      error_count++;
      if (error_count <= 10) begin
        $display("unexpected result transfer: fv=%0d fc=%0d sv=%0d sc=%0d",
                 got.first_valid, got.first_column, got.second_valid, got.second_column);
      end
      return;
    end
    want = pending_results.pop_front();
    if (got.first_valid !== want.first_valid || got.first_column !== want.first_column ||
        got.second_valid !== want.second_valid || got.second_column !== want.second_column) begin
      error_count++;
      if (error_count <= 10) begin
        $display("result mismatch: expected fv=%0d fc=%0d sv=%0d sc=%0d, got fv=%0d fc=%0d sv=%0d sc=%0d",
                 want.first_valid, want.first_column, want.second_valid, want.second_column,
                 got.first_valid, got.first_column, got.second_valid, got.second_column);
      end
    end
  endtask

  initial begin : result_sink
    int stall;
    int accepted;
    bit burst;
    accepted = 0;
    burst = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      stall = burst ? 0 : $urandom_range(0, 7);
      if (accepted == HOLD_AT) begin
        stall = HOLD_CYCLES;
      end
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      check_result(frame_result_t'(m_tdata[OUT_W-1:0]));
      accepted++;
      if ($urandom_range(0, 15) == 0) begin
        burst = !burst;
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin : stimulus
    point_t p;
    reset_segmenter();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    foreach (dir_rows[i]) begin
      p.column = dir_rows[i].col;
      p.lateral = dir_rows[i].lat;
      p.height = dir_rows[i].hgt;
      p.depth = dir_rows[i].dep;
      send_point(p, dir_rows[i].cend, dir_rows[i].fend, dir_rows[i].typed, dir_rows[i].want);
    end
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph > 0) begin
        wait_drained();
        apply_config(phase_setting(ph));
      end
      if (ph == 1) begin
        saturating_run(COLUMN_MAX, 1027);
        saturating_run(0, COUNT_LIMIT + 2);
      end
      items_sent = 0;
      while (items_sent < phase_items(ph)) begin
        random_frame();
      end
    end
    wait_drained();
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/dcos_pkg.sv
rtl/core/dcos_front.sv
rtl/core/dcos_queue.sv
rtl/core/dcos_back.sv
rtl/core/depth_column_obstacle_segmenter.sv
tb/tb.sv
